// ----- hdl/crf_pkg.sv -----
// shared constants and transfer types for the can frame message reassembler
package crf_pkg;

    // default store size in bytes
    localparam int BUFFER_DEPTH_DEF = 512;
    // message header and frame geometry
    localparam int HEADER_BYTES = 12;
    localparam int FRAME_BYTES  = 8;
    localparam int FRAME_IW     = $clog2(FRAME_BYTES);
    // header byte positions
    localparam int ENDIAN_INDEX = 6;
    localparam int LENGTH_INDEX = 8;
    // header byte 6 value that selects little-endian length
    localparam logic [7:0] ENDIAN_LITTLE = 8'd1;

    // command modes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BUSY      = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_NOT_READY = 2'd3;

    // input item
    typedef struct packed {
        logic        mode;
        logic [63:0] frame_data;
        logic [3:0]  frame_bytes;
        logic [28:0] frame_id;
    } t_cmd;

    // result item
    typedef struct packed {
        logic [1:0]  status;
        logic        message_ready;
        logic [9:0]  message_total;
        logic [7:0]  read_byte;
        logic        read_valid;
        logic        read_last;
        logic [28:0] message_id;
    } t_rsp;

endpackage

// ----- hdl/crf_store.sv -----
// single-port message byte store with registered read data
module crf_store
    import crf_pkg::*;
#(
    parameter int DEPTH = BUFFER_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/crf_hdr.sv -----
// header snoop: captures endian and length bytes and decodes the message total
module crf_hdr
    import crf_pkg::*;
#(
    parameter int DEPTH = BUFFER_DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [CW-1:0] i_index,
    input  logic [7:0]    i_byte,
    output logic          o_overflow,
    output logic [CW-1:0] o_total
);

    localparam int unsigned MAX_BODY = DEPTH - HEADER_BYTES;

    logic        r_little;
    logic [7:0]  r_b0;
    logic [7:0]  r_b1;
    logic [7:0]  r_b2;
    logic [31:0] body;

    // capture header bytes as they are stored
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            if (i_index == CW'(ENDIAN_INDEX)) begin
                r_little <= (i_byte == ENDIAN_LITTLE);
            end
            if (i_index == CW'(LENGTH_INDEX)) begin
                r_b0 <= i_byte;
            end
            if (i_index == CW'(LENGTH_INDEX + 1)) begin
                r_b1 <= i_byte;
            end
            if (i_index == CW'(LENGTH_INDEX + 2)) begin
                r_b2 <= i_byte;
            end
        end
    end

    // last length byte is the one being stored now
    always_comb begin
        if (r_little) begin
            body = {i_byte, r_b2, r_b1, r_b0};
        end else begin
            body = {r_b0, r_b1, r_b2, i_byte};
        end
    end

    assign o_overflow = (body > 32'(MAX_BODY));
    assign o_total    = CW'(HEADER_BYTES) + body[CW-1:0];

endmodule

// ----- hdl/can_frame_message_reassembler_core.sv -----
// top level: command sequencer around the message store and header decoder
//
// Each command holds busy until its result strobe. A push writes its stored
// bytes (data length code clamped to eight) in S_PUSH, one byte per cycle
// into the single-port store, then goes to S_FIN; when the frame runs past
// the message end, its remaining bytes are dropped. A refused or zero-byte
// push, or a read refused as not ready, goes straight to S_FIN. A read passes
// through S_RDWAIT for the store's registered read. The result shows on o_rsp
// with o_valid for one cycle, the first cycle with busy low, and must be taken
// then: there is no backpressure. No clearing pass after reset; the block is
// ready at once.
module can_frame_message_reassembler_core
    import crf_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_valid,
    output t_rsp o_rsp
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PUSH   = 4'b0010,
        S_RDWAIT = 4'b0100,
        S_FIN    = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [FRAME_IW-1:0]  r_idx, n_idx;
    logic [FRAME_IW-1:0]  r_nlast, n_nlast;
    logic [CW-1:0]        r_br, n_br;
    logic [CW-1:0]        r_rp, n_rp;
    logic                 r_known, n_known;
    logic [CW-1:0]        r_total, n_total;
    logic [28:0]          r_held_id, n_held_id;
    logic [1:0]           r_status, n_status;
    logic [7:0]           r_rbyte, n_rbyte;
    logic                 r_rvalid, n_rvalid;
    logic                 r_rlast, n_rlast;
    logic                 r_valid, n_valid;
    t_rsp                 r_rsp, n_rsp;

    logic                 accept;
    logic                 complete;
    logic                 stop;
    logic [3:0]           count;
    logic [7:0]           cur_byte;
    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic [7:0]           mem_rdata;
    logic                 hdr_ovf;
    logic [CW-1:0]        hdr_total;
    logic [CW-1:0]        rp_inc;
    logic [CW+9:0]        total_ext;

    assign accept   = start && (r_state == S_IDLE);
    assign complete = r_known && (r_br >= r_total);
    assign stop     = complete || (r_br >= CW'(BUFFER_DEPTH));
    assign count    = (i_cmd.frame_bytes > 4'(FRAME_BYTES)) ? 4'(FRAME_BYTES)
                                                             : i_cmd.frame_bytes;
    assign cur_byte = r_cmd.frame_data[{r_idx, 3'b000} +: 8];
    assign mem_we   = (r_state == S_PUSH) && !stop;
    assign mem_addr = (r_state == S_PUSH) ? r_br[AW-1:0] : r_rp[AW-1:0];
    assign rp_inc   = r_rp + CW'(1);
    assign total_ext = (CW + 10)'(r_total);

    crf_store #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (cur_byte),
        .o_rdata (mem_rdata)
    );

    crf_hdr #(
        .DEPTH (BUFFER_DEPTH),
        .CW    (CW)
    ) u_hdr (
        .i_clk      (i_clk),
        .i_we       (mem_we),
        .i_index    (r_br),
        .i_byte     (cur_byte),
        .o_overflow (hdr_ovf),
        .o_total    (hdr_total)
    );

    // command sequencer
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_idx     = r_idx;
        n_nlast   = r_nlast;
        n_br      = r_br;
        n_rp      = r_rp;
        n_known   = r_known;
        n_total   = r_total;
        n_held_id = r_held_id;
        n_status  = r_status;
        n_rbyte   = r_rbyte;
        n_rvalid  = r_rvalid;
        n_rlast   = r_rlast;
        n_valid   = 1'b0;
        n_rsp     = r_rsp;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd    = i_cmd;
                    n_idx    = '0;
                    n_rbyte  = '0;
                    n_rvalid = 1'b0;
                    n_rlast  = 1'b0;
                    n_status = ST_OK;
                    if (i_cmd.mode == MODE_PUSH) begin
                        if (complete) begin
                            n_status = ST_BUSY;
                            n_state  = S_FIN;
                        end else begin
                            n_held_id = i_cmd.frame_id;
                            n_nlast   = FRAME_IW'(count - 4'd1);
                            n_state   = (count == 4'd0) ? S_FIN : S_PUSH;
                        end
                    end else begin
                        if (complete) begin
                            // store read is issued at r_rp this cycle
                            n_state = S_RDWAIT;
                        end else begin
                            n_status = ST_NOT_READY;
                            n_state  = S_FIN;
                        end
                    end
                end
            end
            S_PUSH: begin
                if (stop) begin
                    // bytes beyond the message end are dropped
                    n_state = S_FIN;
                end else begin
                    n_br    = r_br + CW'(1);
                    n_idx   = r_idx + FRAME_IW'(1);
                    n_state = (r_idx == r_nlast) ? S_FIN : S_PUSH;
                    if (!r_known && (r_br == CW'(HEADER_BYTES - 1))) begin
                        if (hdr_ovf) begin
                            n_br     = '0;
                            n_rp     = '0;
                            n_known  = 1'b0;
                            n_total  = '0;
                            n_status = ST_OVERFLOW;
                            n_state  = S_FIN;
                        end else begin
                            n_known = 1'b1;
                            n_total = hdr_total;
                        end
                    end
                end
            end
            S_RDWAIT: begin
                n_rbyte  = mem_rdata;
                n_rvalid = 1'b1;
                n_rp     = rp_inc;
                n_state  = S_FIN;
                if (rp_inc >= r_total) begin
                    n_rlast = 1'b1;
                    n_br    = '0;
                    n_rp    = '0;
                    n_known = 1'b0;
                    n_total = '0;
                end
            end
            S_FIN: begin
                // result reflects the state after the command
                n_valid               = 1'b1;
                n_rsp.status          = r_status;
                n_rsp.message_ready   = complete;
                n_rsp.message_total   = total_ext[9:0];
                n_rsp.read_byte       = r_rbyte;
                n_rsp.read_valid      = r_rvalid;
                n_rsp.read_last       = r_rlast;
                n_rsp.message_id      = complete ? r_held_id : '0;
                n_state               = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_br      <= '0;
            r_rp      <= '0;
            r_known   <= 1'b0;
            r_total   <= '0;
            r_held_id <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_br      <= n_br;
            r_rp      <= n_rp;
            r_known   <= n_known;
            r_total   <= n_total;
            r_held_id <= n_held_id;
            r_valid   <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_nlast  <= n_nlast;
        r_status <= n_status;
        r_rbyte  <= n_rbyte;
        r_rvalid <= n_rvalid;
        r_rlast  <= n_rlast;
        r_rsp    <= n_rsp;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ----- hdl/crf_check.sv -----
// port-level checks for the reassembler, bound to the top level
module crf_check
    import crf_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input t_rsp o_rsp
);

    // an accepted command always holds the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // results never come on consecutive cycles
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // a final byte read clears the message
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.read_last) |-> (o_rsp.read_valid && !o_rsp.message_ready))
        else $error("final byte read left a message held");

    // a refused frame only happens while a complete message waits
    a_busy_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status == ST_BUSY)) |-> o_rsp.message_ready)
        else $error("frame refused without a held message");

    // no identifier is shown without a held message
    a_id_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.message_ready) |-> (o_rsp.message_id == '0))
        else $error("message id shown without a held message");

endmodule

bind can_frame_message_reassembler_core crf_check u_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);

// ----- sim/testbench.sv -----
// self-checking testbench for the can frame message reassembler core
module testbench;
    import crf_pkg::*;

    // expected-result predictor for message reassembly, with its own copy of the state
    class reassembly_scoreboard;
        logic [7:0]  store [0:BUFFER_DEPTH_DEF-1];
        int unsigned received;
        logic [31:0] body_len;
        bit          len_known;
        int unsigned rd_ptr;
        logic [28:0] held_id;
        t_rsp        expected_rsp [$];
        int          failures;

        function new();
            foreach (store[i]) store[i] = 8'h00;
            received  = 0;
            body_len  = '0;
            len_known = 1'b0;
            rd_ptr    = 0;
            held_id   = '0;
            failures  = 0;
        endfunction

        function logic [63:0] total_bytes();
            return 64'(HEADER_BYTES) + {32'd0, body_len};
        endfunction

        function bit is_complete();
            return len_known && (64'(received) >= total_bytes());
        endfunction

        function bit is_empty();
            return (received == 0) && !len_known;
        endfunction

        function void clear_message();
            received  = 0;
            body_len  = '0;
            len_known = 1'b0;
            rd_ptr    = 0;
        endfunction

        // length field from header bytes 8..11, byte order picked by header byte 6
        function logic [31:0] decoded_length();
            if (store[ENDIAN_INDEX] == ENDIAN_LITTLE) begin
                return {store[LENGTH_INDEX+3], store[LENGTH_INDEX+2],
                        store[LENGTH_INDEX+1], store[LENGTH_INDEX]};
            end
            return {store[LENGTH_INDEX], store[LENGTH_INDEX+1],
                    store[LENGTH_INDEX+2], store[LENGTH_INDEX+3]};
        endfunction

        // append one frame; bytes past the message end are dropped
        function logic [1:0] take_frame(t_cmd c);
            int n;
            int i;
            n = (c.frame_bytes > FRAME_BYTES) ? FRAME_BYTES : int'(c.frame_bytes);
            if (is_complete()) return ST_BUSY;
            held_id = c.frame_id;
            for (i = 0; i < n; i++) begin
                if (len_known && (64'(received) >= total_bytes())) break;
                if (received >= BUFFER_DEPTH_DEF) break;
                store[received] = c.frame_data[8*i +: 8];
                received++;
                if (!len_known && received >= HEADER_BYTES) begin
                    body_len  = decoded_length();
                    len_known = 1'b1;
                    if (total_bytes() > 64'(BUFFER_DEPTH_DEF)) begin
                        clear_message();
                        return ST_OVERFLOW;
                    end
                end
            end
            return ST_OK;
        endfunction

        // accepted command: advance the state and queue the result it causes
        function void note_command(t_cmd c);
            t_rsp        r;
            logic [63:0] tot;
            bit          ready;
            r = '0;
            if (c.mode == MODE_PUSH) begin
                r.status = take_frame(c);
            end else if (!is_complete()) begin
                r.status = ST_NOT_READY;
            end else begin
                r.status     = ST_OK;
                r.read_byte  = store[rd_ptr];
                r.read_valid = 1'b1;
                rd_ptr++;
                if (64'(rd_ptr) >= total_bytes()) begin
                    r.read_last = 1'b1;
                    clear_message();
                end
            end
            ready           = is_complete();
            tot             = total_bytes();
            r.message_ready = ready;
            r.message_total = len_known ? tot[9:0] : 10'd0;
            r.message_id    = ready ? held_id : 29'd0;
            expected_rsp.push_back(r);
        endfunction

        // compare one result transfer with the oldest expectation
        function void check_result(t_rsp got);
            t_rsp want;
            if (expected_rsp.size() == 0) begin
                failures++;
                if (failures <= 10) $display("result with none expected: %h", got);
                return;
            end
            want = expected_rsp.pop_front();
            if (got.status !== want.status || got.message_ready !== want.message_ready ||
                got.message_total !== want.message_total ||
                got.read_byte !== want.read_byte || got.read_valid !== want.read_valid ||
                got.read_last !== want.read_last || got.message_id !== want.message_id) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch: status %0d/%0d ready %0d/%0d total %0d/%0d",
                             want.status, got.status, want.message_ready,
                             got.message_ready, want.message_total, got.message_total);
                    $display("  byte %h/%h valid %0d/%0d last %0d/%0d id %h/%h",
                             want.read_byte, got.read_byte, want.read_valid, got.read_valid,
                             want.read_last, got.read_last, want.message_id, got.message_id);
                end
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_cmd i_cmd   = '0;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;

    reassembly_scoreboard sb;
    int issued   = 0;
    int idle_pct = 0;

    can_frame_message_reassembler_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) sb.check_result(o_rsp);
    end

    function automatic t_cmd push_cmd(logic [63:0] data, logic [3:0] nb, logic [28:0] id);
        t_cmd c;
        c.mode        = MODE_PUSH;
        c.frame_data  = data;
        c.frame_bytes = nb;
        c.frame_id    = id;
        return c;
    endfunction

    function automatic t_cmd noise_push();
        return push_cmd({$urandom, $urandom}, 4'($urandom_range(15)), 29'($urandom));
    endfunction

    // read with random filler in the unused fields
    function automatic t_cmd read_cmd();
        t_cmd c;
        c      = noise_push();
        c.mode = MODE_READ;
        return c;
    endfunction

    // one command transfer: optional random gap, then hold start until accepted
    task automatic issue(input t_cmd c);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_command(c);
        issued++;
    endtask

    // read out any complete message and push junk until the store is empty again
    task automatic settle();
        while (!sb.is_empty()) begin
            if (sb.is_complete()) begin
                if ($urandom_range(99) < 3) issue(noise_push());
                issue(read_cmd());
            end else begin
                issue(noise_push());
            end
        end
    endtask

    // message with random header, body and frame sizes; oversize sends only a header whose length overflows
    task automatic send_message(input int body, input bit oversize);
        logic [7:0]  msg [0:527];
        logic [31:0] len;
        logic [63:0] data;
        bit          little;
        int          limit;
        int          pos;
        int          nb;
        int          k;
        for (k = 0; k < 528; k++) msg[k] = 8'($urandom);
        if ($urandom_range(1)) msg[ENDIAN_INDEX] = ENDIAN_LITTLE;
        little = (msg[ENDIAN_INDEX] == ENDIAN_LITTLE);
        len = 32'(body);
        if (oversize) begin
            len = $urandom_range(1) ? 32'($urandom_range(700, BUFFER_DEPTH_DEF - HEADER_BYTES + 1))
                                    : 32'($urandom);
        end
        for (k = 0; k < 4; k++) begin
            msg[LENGTH_INDEX+k] = little ? len[8*k +: 8] : len[8*(3-k) +: 8];
        end
        limit = oversize ? HEADER_BYTES : HEADER_BYTES + body;
        pos = 0;
        while (pos < limit) begin
            if ($urandom_range(99) < 4) issue(read_cmd());
            nb = $urandom_range(15);
            for (k = 0; k < 8; k++) data[8*k +: 8] = msg[pos+k];
            issue(push_cmd(data, 4'(nb), 29'($urandom)));
            pos += (nb > FRAME_BYTES) ? FRAME_BYTES : nb;
        end
        // frame offered while the message waits to be read
        if ($urandom_range(99) < 20) issue(noise_push());
        settle();
    endtask

    // stimulus
    initial begin
        int pick;
        int k;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: read on empty store, zero-byte frame
        idle_pct = 8;
        issue(read_cmd());
        issue(push_cmd(64'h0, 4'd0, 29'h1FFF_FFFF));
        // little-endian header with empty body, read too early, trailing bytes dropped
        issue(push_cmd(64'h1701_1514_1312_1110, 4'd8, 29'h0));
        issue(read_cmd());
        issue(push_cmd({32'hA5A5_5A5A, 32'h0}, 4'd15, 29'h0AAA_5555));
        issue(noise_push());
        for (k = 0; k < HEADER_BYTES; k++) issue(read_cmd());
        // all-ones length overflows, rest of frame dropped
        issue(push_cmd({64{1'b1}}, 4'd8, 29'h1555_AAAA));
        issue(push_cmd({64{1'b1}}, 4'd8, 29'h1FFF_FFFF));
        // big-endian length one past the store size
        issue(push_cmd(64'h0700_0504_0302_0100, 4'd8, 29'h0123_4567));
        issue(push_cmd({32'h0, 8'hF5, 8'h01, 8'h00, 8'h00}, 4'd4, 29'h0765_4321));
        settle();

        // random messages, mostly small, a few at the largest size
        while (issued < 1350) begin
            idle_pct = (issued < 450) ? 8 : (issued < 900) ? 77 : 0;
            pick = $urandom_range(99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(1)) issue(noise_push());
                    else issue(read_cmd());
                end
                settle();
            end else if (pick < 16) begin
                send_message(0, 1'b1);
            end else if (pick < 19) begin
                send_message($urandom_range(1) ? 500 : $urandom_range(480, 499), 1'b0);
            end else if (pick < 29) begin
                send_message($urandom_range(41, 200), 1'b0);
            end else begin
                send_message($urandom_range(0, 40), 1'b0);
            end
        end
        start <= 1'b0;

        while (sb.expected_rsp.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.failures == 0 && sb.expected_rsp.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
